@@ rtl/fastcgi_response_deframer_top_macros.svh @@
// Assertion macros shared by the response deframer modules.
`ifndef FASTCGI_RESPONSE_DEFRAMER_TOP_MACROS_SVH
`define FASTCGI_RESPONSE_DEFRAMER_TOP_MACROS_SVH
`ifndef SYNTH
`define FCGI_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("fcgi deframer: property violated");
`define FCGI_NEVER(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error("fcgi deframer: forbidden condition seen");
`else
`define FCGI_ASSERT(label, prop)
`define FCGI_NEVER(label, cond)
`endif
`endif

@@ rtl/fcgi_rd_pkg.sv @@
// Shared types and constants of the FastCGI response deframer.
package fcgi_rd_pkg;

   localparam int unsigned ByteW   = 8;
   localparam int unsigned ReqIdW  = 16;
   localparam int unsigned LenW    = 16;
   localparam int unsigned HdrIdxW = 3;

   localparam logic [ReqIdW-1:0] REQ_ID_RESET = 16'd1;

   localparam logic [ByteW-1:0] FCGI_VERSION     = 8'd1;
   localparam logic [ByteW-1:0] TYPE_ABORT       = 8'd2;
   localparam logic [ByteW-1:0] TYPE_END_REQUEST = 8'd3;
   localparam logic [ByteW-1:0] TYPE_STDOUT      = 8'd6;

   // byte positions within the 8-byte record header
   localparam logic [HdrIdxW-1:0] HDR_VERSION  = 3'd0;
   localparam logic [HdrIdxW-1:0] HDR_TYPE     = 3'd1;
   localparam logic [HdrIdxW-1:0] HDR_ID_HI    = 3'd2;
   localparam logic [HdrIdxW-1:0] HDR_ID_LO    = 3'd3;
   localparam logic [HdrIdxW-1:0] HDR_LEN_HI   = 3'd4;
   localparam logic [HdrIdxW-1:0] HDR_LEN_LO   = 3'd5;
   localparam logic [HdrIdxW-1:0] HDR_PAD_LEN  = 3'd6;
   localparam logic [HdrIdxW-1:0] HDR_RESERVED = 3'd7;

   typedef enum logic [2:0] {
      ST_RUNNING     = 3'd0,
      ST_DONE        = 3'd1,
      ST_BAD_VERSION = 3'd2,
      ST_ID_MISMATCH = 3'd3,
      ST_ABORT       = 3'd4,
      ST_UNKNOWN     = 3'd5
   } status_type;

   typedef struct packed {
      logic             payload_valid;
      logic [ByteW-1:0] payload_byte;
      status_type       status;
   } rsp_type;

endpackage

@@ rtl/fcgi_rd_parser.sv @@
// Record parser: per-byte state update and result of one request.
`include "fastcgi_response_deframer_top_macros.svh"

module fcgi_rd_parser (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            accept,
   input  logic [fcgi_rd_pkg::ByteW-1:0]   data_byte,
   input  logic                            restart,
   input  logic [fcgi_rd_pkg::ReqIdW-1:0]  expected_id,
   output fcgi_rd_pkg::rsp_type            result
);
   import fcgi_rd_pkg::*;

   typedef enum logic [1:0] {
      PH_HEADER  = 2'd0,
      PH_CONTENT = 2'd1,
      PH_PADDING = 2'd2,
      PH_HALTED  = 2'd3
   } phase_type;

   phase_type          phase_ff, phase_in, phase_cur;
   logic [HdrIdxW-1:0] hdr_idx_ff, hdr_idx_in, hdr_idx_cur;
   logic [ByteW-1:0]   id_high_ff, id_high_in, id_high_cur;
   logic [ByteW-1:0]   rec_type_ff, rec_type_in, rec_type_cur;
   logic [LenW-1:0]    content_left_ff, content_left_in, content_left_cur;
   logic [ByteW-1:0]   padding_left_ff, padding_left_in, padding_left_cur;
   status_type         status_ff, status_in, status_cur;
   logic               valid_out;

   // clear the parse state ahead of a restart byte
   always_comb begin
      phase_cur        = phase_ff;
      hdr_idx_cur      = hdr_idx_ff;
      id_high_cur      = id_high_ff;
      rec_type_cur     = rec_type_ff;
      content_left_cur = content_left_ff;
      padding_left_cur = padding_left_ff;
      status_cur       = status_ff;
      if (restart) begin
         phase_cur        = PH_HEADER;
         hdr_idx_cur      = '0;
         id_high_cur      = '0;
         rec_type_cur     = '0;
         content_left_cur = '0;
         padding_left_cur = '0;
         status_cur       = ST_RUNNING;
      end
   end

   // advance the record walk by one byte
   always_comb begin
      phase_in        = phase_cur;
      hdr_idx_in      = hdr_idx_cur;
      id_high_in      = id_high_cur;
      rec_type_in     = rec_type_cur;
      content_left_in = content_left_cur;
      padding_left_in = padding_left_cur;
      status_in       = status_cur;
      valid_out       = 1'b0;
      case (phase_cur)
         PH_HEADER: begin
            hdr_idx_in = hdr_idx_cur + HdrIdxW'(1);
            case (hdr_idx_cur)
               HDR_VERSION: begin
                  if (data_byte != FCGI_VERSION) begin
                     status_in = ST_BAD_VERSION;
                     phase_in  = PH_HALTED;
                  end
               end
               HDR_TYPE:    rec_type_in = data_byte;
               HDR_ID_HI:   id_high_in  = data_byte;
               HDR_ID_LO: begin
                  if ({id_high_cur, data_byte} != expected_id) begin
                     status_in = ST_ID_MISMATCH;
                     phase_in  = PH_HALTED;
                  end
               end
               HDR_LEN_HI:  content_left_in = {data_byte, content_left_cur[ByteW-1:0]};
               HDR_LEN_LO:  content_left_in = {content_left_cur[LenW-1:ByteW], data_byte};
               HDR_PAD_LEN: padding_left_in = data_byte;
               default: begin
                  // reserved byte closes the header: dispatch on record type
                  if (rec_type_cur == TYPE_END_REQUEST) begin
                     status_in = ST_DONE;
                     phase_in  = PH_HALTED;
                  end else if (rec_type_cur == TYPE_ABORT) begin
                     status_in = ST_ABORT;
                     phase_in  = PH_HALTED;
                  end else if (rec_type_cur != TYPE_STDOUT) begin
                     status_in = ST_UNKNOWN;
                     phase_in  = PH_HALTED;
                  end else if (content_left_cur != '0) begin
                     phase_in = PH_CONTENT;
                  end else begin
                     // empty STDOUT record still skips its padding
                     phase_in   = (padding_left_cur != '0) ? PH_PADDING : PH_HEADER;
                     hdr_idx_in = '0;
                  end
               end
            endcase
         end
         PH_CONTENT: begin
            valid_out       = 1'b1;
            content_left_in = content_left_cur - LenW'(1);
            if (content_left_cur == LenW'(1)) begin
               phase_in   = (padding_left_cur != '0) ? PH_PADDING : PH_HEADER;
               hdr_idx_in = '0;
            end
         end
         PH_PADDING: begin
            padding_left_in = padding_left_cur - ByteW'(1);
            if (padding_left_cur == ByteW'(1)) begin
               phase_in   = PH_HEADER;
               hdr_idx_in = '0;
            end
         end
         default: begin
            // halted: hold everything until restart
         end
      endcase
   end

   // form the result of this request
   always_comb begin
      result.payload_valid = valid_out;
      result.payload_byte  = valid_out ? data_byte : '0;
      result.status        = status_in;
   end

   // hold parse state, update on each accepted request
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_HEADER;
         hdr_idx_ff      <= '0;
         id_high_ff      <= '0;
         rec_type_ff     <= '0;
         content_left_ff <= '0;
         padding_left_ff <= '0;
         status_ff       <= ST_RUNNING;
      end else if (accept) begin
         phase_ff        <= phase_in;
         hdr_idx_ff      <= hdr_idx_in;
         id_high_ff      <= id_high_in;
         rec_type_ff     <= rec_type_in;
         content_left_ff <= content_left_in;
         padding_left_ff <= padding_left_in;
         status_ff       <= status_in;
      end
   end

   `FCGI_ASSERT(a_error_halts, (status_ff != ST_RUNNING) |-> (phase_ff == PH_HALTED))
   `FCGI_ASSERT(a_payload_in_content, result.payload_valid |-> (phase_ff == PH_CONTENT && !restart))
   `FCGI_NEVER(a_content_empty, phase_ff == PH_CONTENT && content_left_ff == '0)
   `FCGI_NEVER(a_padding_empty, phase_ff == PH_PADDING && padding_left_ff == '0)

endmodule

@@ rtl/fastcgi_response_deframer_top.sv @@
// Top level of the FastCGI response deframer: handshake, CSR and result register.
// The result of an accepted request is registered and shows in the next cycle.
// One byte per cycle unless stalled; the per-byte parser update is the only loop.
// The result register decouples the sides: a new request is taken while a result waits
// unless that result is stalled. Synchronous active-high reset returns the parser to
// header phase with status running and sets the expected request id to 1.
`include "fastcgi_response_deframer_top_macros.svh"

module fastcgi_response_deframer_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [fcgi_rd_pkg::ByteW-1:0]   req_data_byte,
   input  logic                            req_restart,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_payload_valid,
   output logic [fcgi_rd_pkg::ByteW-1:0]   rsp_payload_byte,
   output logic [2:0]                      rsp_status,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [fcgi_rd_pkg::ReqIdW-1:0]  csr_data
);
   import fcgi_rd_pkg::*;

   logic              accept;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;
   logic [ReqIdW-1:0] req_id_ff;

   // take a request unless a finished result is stalled
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;
   assign csr_ready = 1'b1;

   fcgi_rd_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .data_byte   (req_data_byte),
      .restart     (req_restart),
      .expected_id (req_id_ff),
      .result      (rsp_in)
   );

   // hold the expected request id
   always_ff @(posedge clock) begin
      if (reset) begin
         req_id_ff <= REQ_ID_RESET;
      end else if (csr_valid && csr_ready) begin
         req_id_ff <= csr_data;
      end
   end

   // keep the result until taken, load a new one on accept
   assign rsp_valid_in = accept | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_payload_valid = rsp_ff.payload_valid;
   assign rsp_payload_byte  = rsp_ff.payload_byte;
   assign rsp_status        = rsp_ff.status;

   `FCGI_ASSERT(a_accept_fills, accept |=> rsp_valid_ff)
   `FCGI_ASSERT(a_stalled_kept, (rsp_valid_ff && rsp_stall) |=> rsp_valid_ff)
   `FCGI_NEVER(a_idle_byte_zero, rsp_valid_ff && !rsp_ff.payload_valid && rsp_ff.payload_byte != '0)

endmodule

@@ verif/tb.sv @@
// Self-checking testbench of the FastCGI response deframer top level.
module tb;
   import fcgi_rd_pkg::*;

   localparam int ClockHalf    = 6;
   localparam int ResetCycles  = 6;
   localparam int StallLimit   = 2000;
   localparam int SegmentItems = 300;
   localparam int Segments     = 6;

   typedef enum logic [1:0] {
      PARSE_HEADER,
      PARSE_CONTENT,
      PARSE_PADDING,
      PARSE_HALTED
   } parse_phase_type;

   typedef struct packed {
      logic [ByteW-1:0] data;
      logic             restart;
   } stream_byte_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [ByteW-1:0]    req_data_byte = '0;
   logic                req_restart = 1'b0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic                rsp_payload_valid;
   logic [ByteW-1:0]    rsp_payload_byte;
   logic [2:0]          rsp_status;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [ReqIdW-1:0]   csr_data = '0;

   // handshake bookkeeping
   logic                req_taken = 1'b0;
   logic                csr_taken = 1'b0;
   logic                draining = 1'b0;
   int                  send_idle_pct = 0;
   int                  recv_idle_pct = 0;
   int                  quiet_cycles = 0;
   int                  fail_count = 0;
   int                  checked_count = 0;
   int                  payload_count = 0;
   int                  stream_items = 0;
   int                  halt_count [8];

   stream_byte_type     pending_q [$];
   rsp_type             expected_rsp_q [$];

   // parser copy used for prediction
   parse_phase_type     parse_phase;
   logic [HdrIdxW-1:0]  hdr_pos;
   logic [ByteW-1:0]    id_hi;
   logic [ByteW-1:0]    rec_type;
   logic [LenW-1:0]     content_cnt;
   logic [ByteW-1:0]    pad_cnt;
   status_type          cur_status;
   logic [ReqIdW-1:0]   expected_id;

   fastcgi_response_deframer_top DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data_byte     (req_data_byte),
      .req_restart       (req_restart),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_payload_valid (rsp_payload_valid),
      .rsp_payload_byte  (rsp_payload_byte),
      .rsp_status        (rsp_status),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_data          (csr_data)
   );

   always begin
      #ClockHalf clock = 1'b1;
      #ClockHalf clock = 1'b0;
   end

   function automatic void clear_parse_state();
      parse_phase = PARSE_HEADER;
      hdr_pos     = '0;
      id_hi       = '0;
      rec_type    = '0;
      content_cnt = '0;
      pad_cnt     = '0;
      cur_status  = ST_RUNNING;
   endfunction

   function automatic void halt_parse(input status_type code);
      cur_status  = code;
      parse_phase = PARSE_HALTED;
      halt_count[code]++;
   endfunction

   function automatic void end_of_content();
      parse_phase = (pad_cnt != 0) ? PARSE_PADDING : PARSE_HEADER;
      hdr_pos     = '0;
   endfunction

   // Advance the parser copy by one byte and return the result it causes.
   function automatic rsp_type deframe_byte(input logic [ByteW-1:0] b, input logic rst);
      rsp_type            r;
      logic [HdrIdxW-1:0] pos;
      r.payload_valid = 1'b0;
      r.payload_byte  = '0;
      if (rst)
         clear_parse_state();
      case (parse_phase)
         PARSE_HEADER: begin
            pos     = hdr_pos;
            hdr_pos = hdr_pos + HdrIdxW'(1);
            case (pos)
               HDR_VERSION: if (b != FCGI_VERSION) halt_parse(ST_BAD_VERSION);
               HDR_TYPE:    rec_type = b;
               HDR_ID_HI:   id_hi = b;
               HDR_ID_LO:   if ({id_hi, b} != expected_id) halt_parse(ST_ID_MISMATCH);
               HDR_LEN_HI:  content_cnt = {b, 8'h00};
               HDR_LEN_LO:  content_cnt[7:0] = b;
               HDR_PAD_LEN: pad_cnt = b;
               default: begin
                  // reserved byte: decide on the record type
                  if (rec_type == TYPE_END_REQUEST)
                     halt_parse(ST_DONE);
                  else if (rec_type == TYPE_ABORT)
                     halt_parse(ST_ABORT);
                  else if (rec_type != TYPE_STDOUT)
                     halt_parse(ST_UNKNOWN);
                  else if (content_cnt != 0)
                     parse_phase = PARSE_CONTENT;
                  else
                     end_of_content();
               end
            endcase
         end
         PARSE_CONTENT: begin
            r.payload_valid = 1'b1;
            r.payload_byte  = b;
            content_cnt     = content_cnt - LenW'(1);
            if (content_cnt == 0)
               end_of_content();
         end
         PARSE_PADDING: begin
            pad_cnt = pad_cnt - ByteW'(1);
            if (pad_cnt == 0) begin
               parse_phase = PARSE_HEADER;
               hdr_pos     = '0;
            end
         end
         default: ;
      endcase
      r.status = cur_status;
      return r;
   endfunction

   task automatic push_byte(input logic [ByteW-1:0] data, input logic rst, input bit counted);
      stream_byte_type item;
      item.data    = data;
      item.restart = rst;
      pending_q    = {pending_q, item};
      if (counted)
         stream_items++;
   endtask

   task automatic push_header(input logic rst, input logic [ByteW-1:0] ver,
                              input logic [ByteW-1:0] typ, input logic [ReqIdW-1:0] id,
                              input logic [LenW-1:0] len, input logic [ByteW-1:0] pad);
      push_byte(ver, rst, 1);
      push_byte(typ, 1'b0, 1);
      push_byte(id[15:8], 1'b0, 1);
      push_byte(id[7:0], 1'b0, 1);
      push_byte(len[15:8], 1'b0, 1);
      push_byte(len[7:0], 1'b0, 1);
      push_byte(pad, 1'b0, 1);
      push_byte(8'($urandom), 1'b0, 1);
   endtask

   // Queue one response: mostly well-formed STDOUT records and a terminator,
   // sometimes a broken header, a truncated record or plain noise.
   task automatic queue_response(input logic [ReqIdW-1:0] id);
      int               n_rec;
      int               len;
      int               pad;
      int               kind;
      int               cut;
      logic             first;
      logic [ByteW-1:0] typ;
      logic [ByteW-1:0] ver;
      first = 1'b1;
      if ($urandom_range(9) == 0) begin
         repeat ($urandom_range(1, 6)) push_byte(8'($urandom), 1'($urandom), 1);
         return;
      end
      n_rec = $urandom_range(3);
      for (int r = 0; r < n_rec; r++) begin
         kind = $urandom_range(99);
         len  = (kind < 10) ? 0 : (kind < 96) ? $urandom_range(1, 12) : $urandom_range(250, 300);
         kind = $urandom_range(99);
         pad  = (kind < 50) ? 0 : (kind < 97) ? $urandom_range(1, 7) : $urandom_range(200, 255);
         push_header(first, FCGI_VERSION, TYPE_STDOUT, id, LenW'(len), ByteW'(pad));
         first = 1'b0;
         cut   = ($urandom_range(29) == 0) ? $urandom_range(len + pad) : -1;
         for (int k = 0; k < len + pad; k++) begin
            if (k == cut)
               return;
            push_byte(8'($urandom), 1'b0, 1);
         end
      end
      kind = $urandom_range(99);
      typ  = 8'($urandom);
      if (typ == TYPE_ABORT || typ == TYPE_END_REQUEST || typ == TYPE_STDOUT)
         typ = 8'hFF;
      ver = ($urandom_range(1) != 0) ? 8'h00 : 8'($urandom_range(2, 255));
      if (kind < 60)
         push_header(first, FCGI_VERSION, TYPE_END_REQUEST, id, 16'd8, 8'd0);
      else if (kind < 68)
         push_header(first, FCGI_VERSION, TYPE_ABORT, id, 16'd0, 8'd0);
      else if (kind < 76)
         push_header(first, FCGI_VERSION, typ, id, LenW'($urandom), 8'($urandom));
      else if (kind < 84)
         push_header(first, ver, TYPE_STDOUT, id, 16'd1, 8'd0);
      else if (kind < 92)
         push_header(first, FCGI_VERSION, TYPE_STDOUT, id ^ (16'd1 << $urandom_range(15)),
                     16'd1, 8'd0);
      else begin
         push_byte(FCGI_VERSION, first, 1);
         repeat ($urandom_range(0, 5)) push_byte(8'($urandom), 1'b0, 1);
         return;
      end
      // trailing bytes the halted block ignores
      repeat ($urandom_range(0, 8)) push_byte(8'($urandom), 1'b0, 1);
   endtask

   // Hold until every queued request is taken and every result has come.
   task automatic wait_idle();
      do begin
         @(negedge clock);
         #1;
      end while (pending_q.size() != 0 || req_valid || expected_rsp_q.size() != 0);
      repeat (2) @(negedge clock);
   endtask

   task automatic write_request_id(input logic [ReqIdW-1:0] id);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= id;
      do
         @(negedge clock);
      while (!csr_taken);
      csr_valid <= 1'b0;
   endtask

   // Drive requests and receiver stalls at the falling edge.
   always @(negedge clock) begin
      stream_byte_type nxt;
      rsp_stall <= !reset && ($urandom_range(99) < recv_idle_pct);
      if (reset)
         req_valid <= 1'b0;
      else if (!req_valid || req_taken) begin
         if (draining) begin
            req_valid <= 1'b0;
            if (expected_rsp_q.size() == 0)
               draining <= 1'b0;
         end else if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            nxt = pending_q.pop_front();
            req_valid     <= 1'b1;
            req_data_byte <= nxt.data;
            req_restart   <= nxt.restart;
            if ($urandom_range(399) == 0)
               draining <= 1'b1;
         end else
            req_valid <= 1'b0;
      end
   end

   // Check results, predict accepted requests and watch for a hang.
   always @(posedge clock) begin
      rsp_type exp_rsp;
      rsp_type pred_rsp;
      if (reset) begin
         req_taken <= 1'b0;
         csr_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && !req_stall;
         csr_taken <= csr_valid && csr_ready;
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp_q.size() == 0) begin
               $error("result with no request pending: status %0d", rsp_status);
               fail_count++;
            end else begin
               exp_rsp = expected_rsp_q.pop_front();
               checked_count++;
               if (exp_rsp.payload_valid)
                  payload_count++;
               if (rsp_payload_valid !== exp_rsp.payload_valid) begin
                  $error("payload_valid: expected %0b, got %0b",
                         exp_rsp.payload_valid, rsp_payload_valid);
                  fail_count++;
               end
               if (rsp_payload_byte !== exp_rsp.payload_byte) begin
                  $error("payload_byte: expected %0h, got %0h",
                         exp_rsp.payload_byte, rsp_payload_byte);
                  fail_count++;
               end
               if (rsp_status !== exp_rsp.status) begin
                  $error("status: expected %0d, got %0d", exp_rsp.status, rsp_status);
                  fail_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            pred_rsp       = deframe_byte(req_data_byte, req_restart);
            expected_rsp_q = {expected_rsp_q, pred_rsp};
         end
         if (csr_valid && csr_ready)
            expected_id = csr_data;
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= StallLimit) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   initial begin
      logic [ReqIdW-1:0] seg_id;
      int                target;
      foreach (halt_count[i])
         halt_count[i] = 0;
      clear_parse_state();
      expected_id = REQ_ID_RESET;
      repeat (ResetCycles) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 14;
      recv_idle_pct = 47;
      // bad version on the first byte, then a halted byte
      push_byte(8'h00, 1'b0, 1);
      push_byte(8'hFF, 1'b0, 1);
      // id mismatch on the low id byte
      push_byte(FCGI_VERSION, 1'b1, 1);
      push_byte(TYPE_STDOUT, 1'b0, 1);
      push_byte(8'h00, 1'b0, 1);
      push_byte(8'h02, 1'b0, 1);
      // one content byte with one padding byte, then end with a body to ignore
      push_header(1'b1, FCGI_VERSION, TYPE_STDOUT, REQ_ID_RESET, 16'd1, 8'd1);
      push_byte(8'hFF, 1'b0, 1);
      push_byte(8'h00, 1'b0, 1);
      push_header(1'b0, FCGI_VERSION, TYPE_END_REQUEST, REQ_ID_RESET, 16'd0, 8'd0);
      push_byte(8'hA5, 1'b0, 1);
      wait_idle();

      for (int seg = 0; seg < Segments; seg++) begin
         case (seg)
            0:       seg_id = 16'hFFFF;
            1:       seg_id = 16'h0000;
            3:       seg_id = 16'h8000;
            5:       seg_id = REQ_ID_RESET;
            default: seg_id = 16'($urandom);
         endcase
         write_request_id(seg_id);
         case (seg / 2)
            0: begin
               send_idle_pct = 14;
               recv_idle_pct = 47;
            end
            1: begin
               send_idle_pct = 47;
               recv_idle_pct = 14;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         target = stream_items + SegmentItems;
         while (stream_items < target)
            queue_response(seg_id);
         wait_idle();
      end

      repeat (3) @(posedge clock);
      $display("tb: %0d results checked, %0d payload bytes, %0d request id settings",
               checked_count, payload_count, Segments + 1);
      $display("tb: halts: done %0d, bad version %0d, id mismatch %0d, abort %0d, unknown %0d",
               halt_count[ST_DONE], halt_count[ST_BAD_VERSION], halt_count[ST_ID_MISMATCH],
               halt_count[ST_ABORT], halt_count[ST_UNKNOWN]);
      if (fail_count == 0 && expected_rsp_q.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
